/* rtl/core/ncc_pkg.sv */
`default_nettype none

package ncc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;

    localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CHAR_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] SUM_NONE    = 8'hFF;
    localparam logic [BYTE_W-1:0] COUNT_MAX   = 8'hFF;

    localparam logic [BYTE_W-1:0] MIN_LENGTH_RESET = 8'd10;

    typedef enum logic [1:0] {
        PH_PAYLOAD = 2'd0,
        PH_HIGH    = 2'd1,
        PH_LOW     = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_MATCH    = 2'd0,
        ST_SHORT    = 2'd1,
        ST_MISMATCH = 2'd2
    } status_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] char_byte;
        logic              end_of_sentence;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [BYTE_W-1:0] computed_sum;
        logic [BYTE_W-1:0] received_sum;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/ncc_if.sv */
`default_nettype none

interface ncc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_sentence;

    modport source (output valid, output char_byte, output end_of_sentence, input ready);
    modport sink   (input valid, input char_byte, input end_of_sentence, output ready);
endinterface

interface ncc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;

    modport source (output valid, output status, output computed_sum,
                    output received_sum, input ready);
    modport sink   (input valid, input status, input computed_sum,
                    input received_sum, output ready);
endinterface

`default_nettype wire

/* rtl/core/ncc_in_stage.sv */
`default_nettype none

module ncc_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    ncc_byte_if.sink            byte_ch,
    input  wire logic           advance,
    output ncc_pkg::item_t      item
);
    import ncc_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              take;

    // Take a new byte when the register is empty or its byte moves on.
    assign byte_ch.ready = !valid_reg || advance;
    assign take          = byte_ch.valid && byte_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= byte_ch.char_byte;
            last_reg <= byte_ch.end_of_sentence;
        end
    end

    assign item.valid           = valid_reg;
    assign item.char_byte       = byte_reg;
    assign item.end_of_sentence = last_reg;

endmodule

`default_nettype wire

/* rtl/core/ncc_core.sv */
`default_nettype none

module ncc_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [ncc_pkg::BYTE_W-1:0]    min_length,
    input  wire ncc_pkg::item_t                item,
    input  wire logic                          advance,
    output ncc_pkg::result_t                   res
);
    import ncc_pkg::*;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic              first_reg;
    logic              first_next;
    logic [BYTE_W-1:0] xor_reg;
    logic [BYTE_W-1:0] xor_next;
    logic [BYTE_W-1:0] high_reg;
    logic [BYTE_W-1:0] high_next;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] sum_next;
    logic [BYTE_W-1:0] count_reg;
    logic [BYTE_W-1:0] count_next;

    phase_t            phase_upd;
    logic [BYTE_W-1:0] xor_upd;
    logic [BYTE_W-1:0] high_upd;
    logic [BYTE_W-1:0] sum_upd;
    logic [BYTE_W-1:0] count_upd;
    logic [BYTE_W-1:0] digit;
    logic              skip_dollar;

    function automatic logic [BYTE_W-1:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        v = SUM_NONE;
        if (c inside {[8'h30:8'h39]})
        begin
            v = c - 8'd48;
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            v = c - 8'd55;
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            v = c - 8'd87;
        end
        return v;
    endfunction

    assign digit       = hex_value(item.char_byte);
    assign skip_dollar = first_reg && (item.char_byte == CHAR_DOLLAR);
    assign count_upd   = (count_reg == COUNT_MAX) ? count_reg : count_reg + 8'd1;

    // Fold one byte into the sentence state.
    always_comb
    begin
        phase_upd = phase_reg;
        xor_upd   = xor_reg;
        high_upd  = high_reg;
        sum_upd   = sum_reg;
        case (phase_reg)
            PH_PAYLOAD:
            begin
                if (item.char_byte == CHAR_STAR)
                begin
                    phase_upd = PH_HIGH;
                end
                else if (!skip_dollar)
                begin
                    xor_upd = xor_reg ^ item.char_byte;
                end
            end
            PH_HIGH:
            begin
                high_upd  = digit;
                phase_upd = PH_LOW;
            end
            PH_LOW:
            begin
                sum_upd   = {high_reg[3:0], 4'h0} | digit;
                phase_upd = PH_DONE;
            end
            default:
            begin
                phase_upd = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        res.computed_sum = xor_upd;
        res.received_sum = sum_upd;
        if (count_upd < min_length)
        begin
            res.status = ST_SHORT;
        end
        else if (phase_upd == PH_PAYLOAD)
        begin
            res.status = ST_MISMATCH;
        end
        else if (xor_upd == sum_upd)
        begin
            res.status = ST_MATCH;
        end
        else
        begin
            res.status = ST_MISMATCH;
        end
    end

    // Clear for the next sentence after the final byte.
    always_comb
    begin
        phase_next = phase_reg;
        first_next = first_reg;
        xor_next   = xor_reg;
        high_next  = high_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        if (advance)
        begin
            if (item.end_of_sentence)
            begin
                phase_next = PH_PAYLOAD;
                first_next = 1'b1;
                xor_next   = '0;
                high_next  = SUM_NONE;
                sum_next   = SUM_NONE;
                count_next = '0;
            end
            else
            begin
                phase_next = phase_upd;
                first_next = 1'b0;
                xor_next   = xor_upd;
                high_next  = high_upd;
                sum_next   = sum_upd;
                count_next = count_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PAYLOAD;
            first_reg <= 1'b1;
            xor_reg   <= '0;
            high_reg  <= SUM_NONE;
            sum_reg   <= SUM_NONE;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            first_reg <= first_next;
            xor_reg   <= xor_next;
            high_reg  <= high_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.end_of_sentence |=>
            first_reg && (count_reg == '0) && (phase_reg == PH_PAYLOAD))
        else $error("sentence state not cleared after final byte");

    a_count_tracks_first: assert property (@(posedge clk) disable iff (!rst_n)
        (first_reg == 1'b1) == (count_reg == '0))
        else $error("byte count disagrees with first-byte flag");

    a_star_seen_not_first: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_PAYLOAD) |-> !first_reg)
        else $error("digit phase reached with no byte seen");

endmodule

`default_nettype wire

/* rtl/core/ncc_out_stage.sv */
`default_nettype none

module ncc_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire ncc_pkg::result_t  res,
    output logic                   can_load,
    ncc_result_if.source           result_ch
);
    import ncc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load = !valid_reg || result_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign result_ch.valid        = valid_reg;
    assign result_ch.status       = res_reg.status;
    assign result_ch.computed_sum = res_reg.computed_sum;
    assign result_ch.received_sum = res_reg.received_sum;

endmodule

`default_nettype wire

/* rtl/core/nmea_checksum_check.sv */
// NMEA 0183 sentence checksum checker.
// sentence_bytes carries one byte of a sentence per item, with
// end_of_sentence set on the final byte. A leading '$' is skipped, bytes up
// to the first '*' are XORed, and the next two bytes are decoded as hex.
// check_result carries one item per sentence: status (match, too short,
// mismatch), the computed XOR and the received checksum.
// min_length is written through min_length_we / min_length_wdata; write it
// only while no sentence is in flight. It resets to 10.
// Throughput: one byte per cycle while each final byte finds room in the
// result register. Each byte passes an input register and the XOR / hex
// decode / compare logic; the result of a final byte is formed from the held
// byte and loaded into the result register, which drives check_result.
// Stall: while the result register holds an untaken item, a following
// final byte waits in the input register; other bytes keep flowing, and
// sentence_bytes.ready drops only when the input register cannot drain.
// Reset: all sentence state clears, both registers empty, min_length is 10.
`default_nettype none

module nmea_checksum_check (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    ncc_byte_if.sink                         sentence_bytes,
    ncc_result_if.source                     check_result,
    input  wire logic                        min_length_we,
    input  wire logic [ncc_pkg::BYTE_W-1:0]  min_length_wdata
);
    import ncc_pkg::*;

    logic [BYTE_W-1:0] min_length_reg;
    item_t             item;
    result_t           res;
    logic              can_load;
    logic              advance;
    logic              load;

    // Min length; the user changes it only between sentences, unchecked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= MIN_LENGTH_RESET;
        end
        else if (min_length_we)
        begin
            min_length_reg <= min_length_wdata;
        end
    end

    // Advance a held byte unless it is a final byte facing a full,
    // stalled result register.
    assign advance = item.valid && (!item.end_of_sentence || can_load);
    assign load    = advance && item.end_of_sentence;

    ncc_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (sentence_bytes),
        .advance (advance),
        .item    (item)
    );

    ncc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .min_length (min_length_reg),
        .item       (item),
        .advance    (advance),
        .res        (res)
    );

    ncc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .res       (res),
        .can_load  (can_load),
        .result_ch (check_result)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(load && check_result.valid && !check_result.ready))
        else $error("result register overwritten while stalled");

    a_held_byte_stays: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && !advance |=>
            item.valid && $stable(item.char_byte) && $stable(item.end_of_sentence))
        else $error("held byte lost while blocked");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        sentence_bytes.valid && sentence_bytes.ready |=> item.valid)
        else $error("accepted byte not held");

endmodule

`default_nettype wire
